// File: design/tcw_pkg.sv
// Shared types and constants for the text console writer.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // Width of one screen cell: attribute in the high byte, character in the low byte.
    localparam int CELL_W = 16;

    // Operation codes carried by the func field.
    localparam logic [2:0] FUNC_PUT_CHAR  = 3'd0;
    localparam logic [2:0] FUNC_SET_COLOR = 3'd1;
    localparam logic [2:0] FUNC_CLEAR     = 3'd2;
    localparam logic [2:0] FUNC_SET_CURSOR = 3'd3;
    localparam logic [2:0] FUNC_READ_CELL = 3'd4;

    // Character and attribute constants.
    localparam logic [7:0] NEWLINE_CODE  = 8'd10;
    localparam logic [7:0] SPACE_CODE    = 8'd32;
    localparam logic [7:0] DEFAULT_COLOR = 8'd15;
    localparam logic [CELL_W-1:0] BLANK_CELL = {DEFAULT_COLOR, SPACE_CODE};

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_BLANK
    } tcw_state_t;

endpackage : tcw_pkg

`default_nettype wire

// File: design/tcw_screen_ram.sv
// Screen store: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module tcw_screen_ram #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  wire logic                      aclk,
    input  wire logic                      wr_en,
    input  wire logic [ADDR_W-1:0]         wr_addr,
    input  wire logic [tcw_pkg::CELL_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0]         rd_addr,
    output logic      [tcw_pkg::CELL_W-1:0] rd_data
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; a same-address write returns old data.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule : tcw_screen_ram

`default_nettype wire

// File: design/text_console_writer_top.sv
// Text console writer: cursor, colour and sequencer around the screen store.
`timescale 1ns / 1ps
`default_nettype none

// Text console over a ROWS x COLUMNS screen of 16-bit cells (attribute high byte,
// character low byte), kept in a single synchronous RAM. Each input beat yields
// exactly one result beat carrying the cursor and colour after the operation and,
// for read cell, the cell contents. Put character (without scroll), set colour,
// set cursor and unused codes finish in the accept cycle, so such beats may arrive
// every cycle while the result side is not stalled; the character write retires
// through a registered write stage that read cell forwards from. Read cell waits
// in the read state for the registered RAM read. Clear screen blanks the whole
// screen, one cell written per cycle. A put character or newline past the bottom
// row scrolls: one cell moved per cycle through the RAM read and write ports, then
// the bottom row blanked. The screen is not cleared by reset; software issues
// clear screen before reading cells.
module text_console_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_func,
    input  wire logic [7:0]  s_char_code,
    input  wire logic [7:0]  s_color_attr,
    input  wire logic [4:0]  s_row_position,
    input  wire logic [6:0]  s_col_position,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_cell_entry,
    output logic [4:0]       m_cursor_row,
    output logic [6:0]       m_cursor_col,
    output logic [7:0]       m_current_color
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    localparam logic [AW-1:0] COPY_LAST = AW'(CELLS - COLUMNS - 1);
    localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
    localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
    localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);

    tcw_state_t state_reg, state_next;
    logic [AW-1:0]     cnt_reg, cnt_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [7:0]        color_reg, color_next;
    logic              m_valid_reg, m_valid_next;
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic              wr_en_reg, wr_en_next;
    logic              wr_copy_reg, wr_copy_next;
    logic [AW-1:0]     wr_addr_reg, wr_addr_next;
    logic [CELL_W-1:0] wr_data_reg, wr_data_next;
    logic              fwd_reg, fwd_next;
    logic [CELL_W-1:0] fwd_data_reg, fwd_data_next;

    logic              accept;
    logic [AW-1:0]     rd_addr;
    logic [CELL_W-1:0] rd_data;
    logic [CELL_W-1:0] ram_wr_data;
    logic [AW-1:0]     cur_addr;
    logic [RW-1:0]     sat_row;
    logic [CW-1:0]     sat_col;
    logic [AW-1:0]     sat_addr;
    logic              at_last_row;
    logic              at_last_col;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    // Cursor address and saturated position for set cursor and read cell.
    assign cur_addr    = AW'(row_reg) * ROW_STEP + AW'(col_reg);
    assign sat_row     = (int'(s_row_position) >= ROWS) ? ROW_LAST : RW'(s_row_position);
    assign sat_col     = (int'(s_col_position) >= COLUMNS) ? COL_LAST : CW'(s_col_position);
    assign sat_addr    = AW'(sat_row) * ROW_STEP + AW'(sat_col);
    assign at_last_row = (row_reg == ROW_LAST);
    assign at_last_col = (col_reg == COL_LAST);

    // During a scroll the read runs one row ahead of the write stage.
    assign rd_addr     = (state_reg == ST_SCROLL) ? (cnt_reg + ROW_STEP) : sat_addr;
    assign ram_wr_data = wr_copy_reg ? rd_data : wr_data_reg;

    tcw_screen_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en_reg),
        .wr_addr (wr_addr_reg),
        .wr_data (ram_wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Sequencer: next state, cursor, colour, write stage and result.
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        color_next    = color_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        cell_next     = cell_reg;
        wr_en_next    = 1'b0;
        wr_copy_next  = 1'b0;
        wr_addr_next  = wr_addr_reg;
        wr_data_next  = wr_data_reg;
        fwd_next      = 1'b0;
        fwd_data_next = wr_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_valid_next = 1'b1;
                    cell_next    = '0;
                    case (s_func)
                        FUNC_PUT_CHAR: begin
                            if (s_char_code == NEWLINE_CODE) begin
                                col_next = '0;
                                if (at_last_row) begin
                                    m_valid_next = 1'b0;
                                    state_next   = ST_SCROLL;
                                    cnt_next     = '0;
                                    color_next   = DEFAULT_COLOR;
                                end else begin
                                    row_next = row_reg + RW'(1);
                                end
                            end else begin
                                wr_en_next   = 1'b1;
                                wr_addr_next = cur_addr;
                                wr_data_next = {color_reg, s_char_code};
                                if (at_last_col) begin
                                    col_next = '0;
                                    if (at_last_row) begin
                                        m_valid_next = 1'b0;
                                        state_next   = ST_SCROLL;
                                        cnt_next     = '0;
                                        color_next   = DEFAULT_COLOR;
                                    end else begin
                                        row_next = row_reg + RW'(1);
                                    end
                                end else begin
                                    col_next = col_reg + CW'(1);
                                end
                            end
                        end
                        FUNC_SET_COLOR: begin
                            color_next = s_color_attr;
                        end
                        FUNC_CLEAR: begin
                            m_valid_next = 1'b0;
                            state_next   = ST_BLANK;
                            cnt_next     = '0;
                            row_next     = '0;
                            col_next     = '0;
                            color_next   = DEFAULT_COLOR;
                        end
                        FUNC_SET_CURSOR: begin
                            row_next = sat_row;
                            col_next = sat_col;
                        end
                        FUNC_READ_CELL: begin
                            // A write still in the stage lands at this edge; forward it.
                            m_valid_next  = 1'b0;
                            state_next    = ST_READ;
                            fwd_next      = wr_en_reg && !wr_copy_reg && (wr_addr_reg == sat_addr);
                            fwd_data_next = wr_data_reg;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                m_valid_next = 1'b1;
                cell_next    = fwd_reg ? fwd_data_reg : rd_data;
                state_next   = ST_IDLE;
            end
            ST_SCROLL: begin
                // Move the cell from one row below into this slot; data arrives next cycle.
                wr_en_next   = 1'b1;
                wr_copy_next = 1'b1;
                wr_addr_next = cnt_reg;
                cnt_next     = cnt_reg + AW'(1);
                if (cnt_reg == COPY_LAST) begin
                    state_next = ST_BLANK;
                end
                row_next = ROW_LAST;
                col_next = '0;
            end
            ST_BLANK: begin
                // Blank cells from the counter to the end of the screen.
                wr_en_next   = 1'b1;
                wr_addr_next = cnt_reg;
                wr_data_next = BLANK_CELL;
                cnt_next     = cnt_reg + AW'(1);
                if (cnt_reg == CELL_LAST) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    cell_next    = '0;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg     <= '0;
            col_reg     <= '0;
            color_reg   <= DEFAULT_COLOR;
            m_valid_reg <= 1'b0;
            wr_en_reg   <= 1'b0;
            wr_copy_reg <= 1'b0;
            fwd_reg     <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            row_reg     <= row_next;
            col_reg     <= col_next;
            color_reg   <= color_next;
            m_valid_reg <= m_valid_next;
            wr_en_reg   <= wr_en_next;
            wr_copy_reg <= wr_copy_next;
            fwd_reg     <= fwd_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cell_reg     <= cell_next;
        wr_addr_reg  <= wr_addr_next;
        wr_data_reg  <= wr_data_next;
        fwd_data_reg <= fwd_data_next;
    end

    // Result beat: cursor and colour hold still while the beat is offered.
    assign m_valid         = m_valid_reg;
    assign m_cell_entry    = cell_reg;
    assign m_cursor_row    = 5'(row_reg);
    assign m_cursor_col    = 7'(col_reg);
    assign m_current_color = color_reg;

`ifndef ASSERT_OFF
    // The cursor never leaves the screen.
    a_cursor_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(row_reg) < ROWS) && (int'(col_reg) < COLUMNS))
        else $error("cursor outside the screen");

    // Copy writes come only from the scroll walk.
    a_copy_from_scroll: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en_reg && wr_copy_reg |-> $past(state_reg) == ST_SCROLL)
        else $error("copy write outside a scroll");

    // A finished blank pass leaves the cursor on column 0 with the default colour.
    a_blank_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BLANK) && (cnt_reg == CELL_LAST) |=>
            (col_reg == '0) && (color_reg == DEFAULT_COLOR) && m_valid_reg)
        else $error("blank pass ended in a wrong state");

    // A result beat appears only when the sequencer is back in idle.
    a_result_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> state_reg == ST_IDLE)
        else $error("result offered while busy");
`endif

endmodule : text_console_writer_top

`default_nettype wire

// File: sim/text_console_writer_top_tb.sv
// Self-checking testbench for the text console writer: directed cases, random traffic, back pressure.
`timescale 1ns / 1ps

module text_console_writer_top_tb;
    import tcw_pkg::*;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    // Function codes that the block leaves without effect.
    localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

    // A scroll or clear walks the whole screen, so the stall limit sits well above that.
    localparam int unsigned STALL_LIMIT     = 20000;
    localparam int unsigned HOLD_OFF_CYCLES = 600;
    localparam int unsigned DRAIN_CYCLES    = 20;
    localparam int unsigned SEGMENT_BEATS   = 500;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] ch;
        logic [7:0] attr;
        logic [4:0] row;
        logic [6:0] col;
    } console_op_t;

    typedef struct packed {
        logic [15:0] entry;
        logic [4:0]  row;
        logic [6:0]  col;
        logic [7:0]  color;
    } console_view_t;

    logic        aclk;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [2:0]  s_func          = '0;
    logic [7:0]  s_char_code     = '0;
    logic [7:0]  s_color_attr    = '0;
    logic [4:0]  s_row_position  = '0;
    logic [6:0]  s_col_position  = '0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [15:0] m_cell_entry;
    logic [4:0]  m_cursor_row;
    logic [6:0]  m_cursor_col;
    logic [7:0]  m_current_color;

    // Shadow copy of the console state, advanced on every accepted input beat.
    logic [15:0]  screen_mem [CELLS];
    int unsigned  cur_row   = 0;
    int unsigned  cur_col   = 0;
    logic [7:0]   cur_color = DEFAULT_COLOR;

    console_view_t views_due [$];
    int unsigned   mismatch_count = 0;
    int unsigned   idle_cycles    = 0;
    int unsigned   beats_sent     = 0;
    bit            tx_gaps_on     = 1'b0;
    bit            rx_stalls_on   = 1'b0;
    bit            hold_off_req   = 1'b0;

    text_console_writer_top #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_char_code    (s_char_code),
        .s_color_attr   (s_color_attr),
        .s_row_position (s_row_position),
        .s_col_position (s_col_position),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cell_entry   (m_cell_entry),
        .m_cursor_row   (m_cursor_row),
        .m_cursor_col   (m_cursor_col),
        .m_current_color(m_current_color)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Idle stretches: mostly none or short, now and then long.
    function automatic int unsigned pick_idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic int unsigned clamp_to(int unsigned v, int unsigned lim);
        return (v >= lim) ? lim - 1 : v;
    endfunction

    // Rows 1..ROWS-1 move up, the bottom row goes blank and the colour returns to default.
    function automatic void scroll_screen();
        for (int i = 0; i < CELLS - COLUMNS; i++) begin
            screen_mem[i] = screen_mem[i + COLUMNS];
        end
        for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
            screen_mem[i] = BLANK_CELL;
        end
        cur_color = DEFAULT_COLOR;
        cur_row   = ROWS - 1;
        cur_col   = 0;
    endfunction

    function automatic void advance_row();
        cur_row++;
        if (cur_row >= ROWS) begin
            scroll_screen();
        end
    endfunction

    function automatic void advance_col();
        cur_col++;
        if (cur_col >= COLUMNS) begin
            cur_col = 0;
            advance_row();
        end
    endfunction

    // Applies one operation to the shadow console and returns what the block should report.
    function automatic console_view_t apply_console_op(console_op_t op);
        console_view_t view;
        view.entry = '0;
        case (op.func)
            FUNC_PUT_CHAR: begin
                if (op.ch == NEWLINE_CODE) begin
                    advance_row();
                    cur_col = 0;
                end else begin
                    screen_mem[cur_row * COLUMNS + cur_col] = {cur_color, op.ch};
                    advance_col();
                end
            end
            FUNC_SET_COLOR: begin
                cur_color = op.attr;
            end
            FUNC_CLEAR: begin
                for (int i = 0; i < CELLS; i++) begin
                    screen_mem[i] = BLANK_CELL;
                end
                cur_color = DEFAULT_COLOR;
                cur_row   = 0;
                cur_col   = 0;
            end
            FUNC_SET_CURSOR: begin
                cur_row = clamp_to(op.row, ROWS);
                cur_col = clamp_to(op.col, COLUMNS);
            end
            FUNC_READ_CELL: begin
                view.entry = screen_mem[clamp_to(op.row, ROWS) * COLUMNS
                                        + clamp_to(op.col, COLUMNS)];
            end
            default: begin
            end
        endcase
        view.row   = cur_row[4:0];
        view.col   = cur_col[6:0];
        view.color = cur_color;
        return view;
    endfunction

    task automatic check_view(input console_view_t want);
        if (m_cell_entry !== want.entry) begin
            $display("%0t: cell_entry expected %h actual %h", $time, want.entry, m_cell_entry);
            mismatch_count++;
        end
        if (m_cursor_row !== want.row) begin
            $display("%0t: cursor_row expected %0d actual %0d", $time, want.row, m_cursor_row);
            mismatch_count++;
        end
        if (m_cursor_col !== want.col) begin
            $display("%0t: cursor_col expected %0d actual %0d", $time, want.col, m_cursor_col);
            mismatch_count++;
        end
        if (m_current_color !== want.color) begin
            $display("%0t: current_color expected %h actual %h", $time, want.color,
                     m_current_color);
            mismatch_count++;
        end
    endtask

    // Predicts on each input beat, checks each result beat, and watches for a hung block.
    always @(posedge aclk) begin : handshake_monitor
        console_op_t   op;
        console_view_t want;
        bit            moved;
        moved = 1'b0;
        if (aresetn && s_valid && s_ready) begin
            op.func = s_func;
            op.ch   = s_char_code;
            op.attr = s_color_attr;
            op.row  = s_row_position;
            op.col  = s_col_position;
            views_due.push_back(apply_console_op(op));
            moved = 1'b1;
        end
        if (aresetn && m_valid && m_ready) begin
            moved = 1'b1;
            if (views_due.size() == 0) begin
                $display("%0t: result beat expected none actual cell %h row %0d col %0d color %h",
                         $time, m_cell_entry, m_cursor_row, m_cursor_col, m_current_color);
                mismatch_count++;
            end else begin
                want = views_due.pop_front();
                check_view(want);
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("text_console_writer_top regression: fail");
            $finish;
        end
    end

    // Result side: random stalls, or one long hold-off when the back-pressure test asks.
    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge aclk);
                hold_off_req = 1'b0;
            end else if (rx_stalls_on && stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                stall_left = rx_stalls_on ? pick_idle_len() : 0;
            end
        end
    end

    // Sends one beat, with an optional idle gap first, and returns once it is accepted.
    task automatic send_op(input console_op_t op);
        int unsigned gap;
        gap = tx_gaps_on ? pick_idle_len() : 0;
        if (gap != 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_func         <= op.func;
        s_char_code    <= op.ch;
        s_color_attr   <= op.attr;
        s_row_position <= op.row;
        s_col_position <= op.col;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    // Every field random; callers override the ones that matter.
    function automatic console_op_t random_fill();
        console_op_t op;
        op.func = 3'($urandom_range(0, 7));
        op.ch   = 8'($urandom_range(0, 255));
        op.attr = 8'($urandom_range(0, 255));
        op.row  = 5'($urandom_range(0, 31));
        op.col  = 7'($urandom_range(0, 127));
        return op;
    endfunction

    task automatic put_char(input logic [7:0] ch);
        console_op_t op;
        op      = random_fill();
        op.func = FUNC_PUT_CHAR;
        op.ch   = ch;
        send_op(op);
    endtask

    task automatic set_color(input logic [7:0] attr);
        console_op_t op;
        op      = random_fill();
        op.func = FUNC_SET_COLOR;
        op.attr = attr;
        send_op(op);
    endtask

    task automatic set_cursor(input logic [4:0] row, input logic [6:0] col);
        console_op_t op;
        op      = random_fill();
        op.func = FUNC_SET_CURSOR;
        op.row  = row;
        op.col  = col;
        send_op(op);
    endtask

    task automatic read_cell(input logic [4:0] row, input logic [6:0] col);
        console_op_t op;
        op      = random_fill();
        op.func = FUNC_READ_CELL;
        op.row  = row;
        op.col  = col;
        send_op(op);
    endtask

    task automatic send_func(input logic [2:0] func);
        console_op_t op;
        op      = random_fill();
        op.func = func;
        send_op(op);
    endtask

    // A single operation drawn by weight: mostly text and reads, clears kept rare.
    function automatic console_op_t random_op();
        console_op_t op;
        int unsigned r;
        op = random_fill();
        r  = $urandom_range(0, 99);
        if (r < 50) begin
            op.func = FUNC_PUT_CHAR;
            if ($urandom_range(0, 99) < 12) begin
                op.ch = NEWLINE_CODE;
            end
        end else if (r < 60) begin
            op.func = FUNC_SET_COLOR;
        end else if (r < 72) begin
            op.func = FUNC_SET_CURSOR;
        end else if (r < 90) begin
            op.func = FUNC_READ_CELL;
        end else if (r < 91) begin
            op.func = FUNC_CLEAR;
        end else begin
            op.func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
        end
        return op;
    endfunction

    // Position the cursor, print a short line, then read part of it back.
    task automatic print_line();
        logic [4:0]  row;
        logic [6:0]  col;
        int unsigned len;
        row = 5'($urandom_range(0, 31));
        col = 7'($urandom_range(0, 127));
        len = $urandom_range(1, 24);
        set_cursor(row, col);
        repeat (len) begin
            if ($urandom_range(0, 99) < 8) begin
                put_char(NEWLINE_CODE);
            end else if ($urandom_range(0, 99) < 10) begin
                set_color(8'($urandom_range(0, 255)));
            end else begin
                put_char(8'($urandom_range(0, 255)));
            end
        end
        repeat ($urandom_range(1, 3)) begin
            read_cell(row, 7'(col + $urandom_range(0, len)));
        end
    endtask

    // Print across the end of the bottom row so the screen scrolls.
    task automatic print_at_bottom();
        set_color(8'($urandom_range(0, 255)));
        set_cursor(5'(ROWS - 1 + $urandom_range(0, 7)), 7'($urandom_range(COLUMNS - 6, 127)));
        repeat ($urandom_range(1, 10)) put_char(8'($urandom_range(0, 255)));
        read_cell(5'(ROWS - 2), 7'($urandom_range(0, 127)));
    endtask

    task automatic test_reset_state();
        send_func(FUNC_SPARE_LO);
    endtask

    // Only the cell just written is read; the rest of the screen is still undefined.
    task automatic test_put_and_read();
        put_char(8'h41);
        read_cell(5'd0, 7'd0);
    endtask

    task automatic test_clear_screen();
        send_func(FUNC_CLEAR);
        read_cell(5'd31, 7'd127);
    endtask

    task automatic test_color_extremes();
        set_color(8'hFF);
        put_char(8'h00);
        set_color(8'h00);
        put_char(8'hFF);
        read_cell(5'd0, 7'd0);
        read_cell(5'd0, 7'd1);
    endtask

    task automatic test_cursor_saturation();
        set_cursor(5'd31, 7'd127);
        set_cursor(5'd0, 7'd0);
    endtask

    task automatic test_wrap_and_newline();
        set_cursor(5'd0, 7'(COLUMNS - 1));
        put_char(8'h78);
        put_char(NEWLINE_CODE);
    endtask

    // Wrap off the last cell scrolls; the written cells must land one row up.
    task automatic test_scroll();
        set_color(8'h1E);
        set_cursor(5'(ROWS - 1), 7'(COLUMNS - 2));
        put_char(8'h79);
        put_char(8'h7A);
        read_cell(5'(ROWS - 2), 7'(COLUMNS - 2));
        read_cell(5'(ROWS - 2), 7'(COLUMNS - 1));
        read_cell(5'(ROWS - 1), 7'd0);
        put_char(NEWLINE_CODE);
        send_func(FUNC_SPARE_HI);
    endtask

    // Four segments, each with a different mix of sender gaps and receiver stalls.
    task automatic test_random_traffic();
        int unsigned goal;
        int unsigned r;
        for (int seg = 0; seg < 4; seg++) begin
            tx_gaps_on   = seg[0];
            rx_stalls_on = seg[1];
            goal         = beats_sent + SEGMENT_BEATS;
            while (beats_sent < goal) begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    send_op(random_op());
                end else if (r < 95) begin
                    print_line();
                end else begin
                    print_at_bottom();
                end
            end
        end
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
    endtask

    // The receiver holds off while the sender keeps offering beats.
    task automatic test_back_pressure();
        set_cursor(5'd3, 7'd0);
        hold_off_req = 1'b1;
        repeat (60) begin
            if ($urandom_range(0, 99) < 15) begin
                set_color(8'($urandom_range(0, 255)));
            end else begin
                put_char(8'($urandom_range(0, 255)));
            end
        end
        wait (!hold_off_req);
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_put_and_read();
        test_clear_screen();
        test_color_extremes();
        test_cursor_saturation();
        test_wrap_and_newline();
        test_scroll();
        test_back_pressure();
        test_random_traffic();

        @(negedge aclk);
        s_valid <= 1'b0;
        while (views_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("text_console_writer_top regression: pass");
        end else begin
            $display("text_console_writer_top regression: fail");
        end
        $finish;
    end

endmodule
